>>> rtl/page_frame_cache_fifo_core_defines.svh
// Assertion macros shared by the page frame cache.
`ifndef PAGE_FRAME_CACHE_FIFO_CORE_DEFINES_SVH
`define PAGE_FRAME_CACHE_FIFO_CORE_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define PFC_ASSERT_IMP(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("page frame cache check failed");

// Check that a condition implies another in the next cycle.
`define PFC_ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("page frame cache check failed");

`endif

>>> rtl/pfc_pkg.sv
`timescale 1ns / 1ps
package pfc_pkg;

  localparam int FRAME_COUNT     = 64;
  localparam int FRAME_IDX_BITS  = $clog2(FRAME_COUNT);
  localparam int FRAME_FLD_BITS  = 6;
  localparam int PAGE_BITS       = 32;
  localparam int STATUS_BITS     = 3;
  localparam int OUT_DATA_BITS   = 72;

  typedef logic [PAGE_BITS-1:0]   page_t;
  typedef logic [STATUS_BITS-1:0] status_t;

  localparam status_t ST_HIT   = 3'd0;
  localparam status_t ST_MISS  = 3'd1;
  localparam status_t ST_ALLOC = 3'd2;
  localparam status_t ST_RANGE = 3'd3;
  localparam status_t ST_FULL  = 3'd4;

  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_ALLOC  = 1'b1;

  // Broadcast command from the sequencer to every cell.
  typedef struct packed {
    logic  advance;    // pass the victim token to the next cell
    logic  fill;       // the token holder takes the new tag
    logic  purge;      // other matching cells drop their copy
    logic  dirty_new;  // dirty bit for the filled frame
    page_t key;        // page compared and written
  } cell_ctl_t;

  // Status of one cell toward the sequencer.
  typedef struct packed {
    logic  match;      // valid and tag equals key
    logic  token;      // this cell is the next victim
    logic  wb;         // valid and dirty
    page_t tag;
  } cell_info_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EVAL = 2'b10
  } state_t;

endpackage

>>> rtl/pfc_cell.sv
`timescale 1ns / 1ps
module pfc_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               token_init,
  input  logic               token_in,
  input  pfc_pkg::cell_ctl_t ctl,
  output pfc_pkg::cell_info_t info
);
  import pfc_pkg::*;

  page_t tag;
  logic  valid;
  logic  dirty;
  logic  token;
  logic  match;

  assign match = valid && (tag == ctl.key);

  // Fill when holding the token, otherwise drop a stale copy.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      dirty <= 1'b0;
      token <= token_init;
    end else begin
      if (ctl.fill && token) begin
        valid <= 1'b1;
        dirty <= ctl.dirty_new;
      end else if (ctl.purge && match) begin
        valid <= 1'b0;
        dirty <= 1'b0;
      end
      if (ctl.advance) begin
        token <= token_in;
      end
    end
  end

  // Tag store carries no reset.
  always_ff @(posedge clk) begin
    if (ctl.fill && token) begin
      tag <= ctl.key;
    end
  end

  assign info.match = match;
  assign info.token = token;
  assign info.wb    = valid && dirty;
  assign info.tag   = tag;

endmodule

>>> rtl/page_frame_cache_fifo_core.sv
`timescale 1ns / 1ps
// Page frame cache tag and replacement core: a ring of 64 frame cells, each
// holding a tag with valid and dirty bits, compared in parallel against one
// key, with the round-robin victim kept as a token that one cell hands to
// its neighbor on each eviction. Each item first has its request captured,
// then the parallel tag compare and state update run once the output
// register is free; a new item is not taken until the last one is done, and
// one result item comes out per input item. s_tuser carries the mode (0
// lookup, 1 allocate), m_tuser the status. Writing the configuration
// channel sets the page count; write it only while no item is in flight.
module page_frame_cache_fifo_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] page_number
  input  logic [0:0]  s_tuser,   // [0] mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // [5:0] frame_index, [37:6] resolved_page,
                                 // [38] writeback_needed,
                                 // [70:39] writeback_page, [71] load_needed
  output logic [2:0]  m_tuser,   // [2:0] status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data   // [31:0] initial_page_count
);
  import pfc_pkg::*;

  state_t     state;
  logic       req_mode;
  page_t      req_page;
  page_t      page_count;
  page_t      page_count_next;
  cell_ctl_t  ctl;
  cell_info_t info [FRAME_COUNT];
  logic [FRAME_COUNT-1:0] match_vec;
  logic [FRAME_COUNT-1:0] token_vec;

  logic                      go;
  logic                      any_match;
  logic                      wb_victim;
  logic [FRAME_IDX_BITS-1:0] hit_idx;
  logic [FRAME_IDX_BITS-1:0] vic_idx;
  page_t                     vic_tag;

  status_t                   res_status;
  logic [FRAME_IDX_BITS-1:0] res_frame;
  page_t                     res_page;
  logic                      res_wb;
  page_t                     res_wb_page;
  logic                      res_load;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign go        = (state == S_EVAL) && (!m_tvalid || m_tready);

  // Ring of frame cells; the token moves from cell i-1 into cell i.
  for (genvar g = 0; g < FRAME_COUNT; g++) begin : g_cell
    pfc_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .token_init ((g == 0) ? 1'b1 : 1'b0),
      .token_in   (info[(g + FRAME_COUNT - 1) % FRAME_COUNT].token),
      .ctl        (ctl),
      .info       (info[g])
    );
    assign match_vec[g] = info[g].match;
    assign token_vec[g] = info[g].token;
  end

  // Encode the single matching frame and the victim frame.
  always_comb begin
    hit_idx   = '0;
    vic_idx   = '0;
    vic_tag   = '0;
    wb_victim = 1'b0;
    for (int i = 0; i < FRAME_COUNT; i++) begin
      if (match_vec[i]) hit_idx = hit_idx | FRAME_IDX_BITS'(i);
      if (token_vec[i]) begin
        vic_idx   = vic_idx | FRAME_IDX_BITS'(i);
        vic_tag   = vic_tag | info[i].tag;
        wb_victim = wb_victim | info[i].wb;
      end
    end
    any_match = |match_vec;
  end

  // Decide the result and the cell command for the held request.
  always_comb begin
    ctl.advance     = 1'b0;
    ctl.fill        = 1'b0;
    ctl.purge       = 1'b0;
    ctl.dirty_new   = 1'b0;
    ctl.key         = (req_mode == MODE_ALLOC) ? page_count : req_page;
    page_count_next = page_count;
    res_status      = ST_RANGE;
    res_frame       = '0;
    res_page        = '0;
    res_wb          = 1'b0;
    res_wb_page     = '0;
    res_load        = 1'b0;
    if (req_mode == MODE_LOOKUP) begin
      if (req_page >= page_count) begin
        res_status = ST_RANGE;
      end else if (any_match) begin
        res_status = ST_HIT;
        res_frame  = hit_idx;
        res_page   = req_page;
      end else begin
        res_status  = ST_MISS;
        res_frame   = vic_idx;
        res_page    = req_page;
        res_wb      = wb_victim;
        res_wb_page = wb_victim ? vic_tag : '0;
        res_load    = 1'b1;
        ctl.advance = go;
        ctl.fill    = go;
      end
    end else begin
      if (page_count == '1) begin
        res_status = ST_FULL;
      end else begin
        res_status      = ST_ALLOC;
        res_frame       = vic_idx;
        res_page        = page_count;
        res_wb          = wb_victim;
        res_wb_page     = wb_victim ? vic_tag : '0;
        ctl.advance     = go;
        ctl.fill        = go;
        ctl.purge       = go;
        ctl.dirty_new   = 1'b1;
        page_count_next = page_count + 1'b1;
      end
    end
  end

  // Advance the sequencer, page count and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      page_count <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        page_count <= cfg_data;
      end else if (go) begin
        page_count <= page_count_next;
      end
      if (go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) state <= S_EVAL;
        end
        S_EVAL: begin
          if (go) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Capture the request and the result payload.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req_mode <= s_tuser[0];
      req_page <= s_tdata;
    end
    if (go) begin
      m_tuser <= res_status;
      m_tdata <= {res_load, res_wb_page, res_wb, res_page,
                  FRAME_FLD_BITS'(res_frame)};
    end
  end

`include "page_frame_cache_fifo_core_defines.svh"

  `PFC_ASSERT_IMP(a_token_onehot, 1'b1, $onehot(token_vec))
  `PFC_ASSERT_IMP(a_match_unique, state == S_EVAL, $onehot0(match_vec))
  `PFC_ASSERT_NEXT(a_accept_eval, s_tvalid && s_tready, state == S_EVAL)
  `PFC_ASSERT_IMP(a_reject_empty,
    m_tvalid && (m_tuser == ST_RANGE || m_tuser == ST_FULL), m_tdata == '0)

endmodule
